// ===== rtl/core/cci_pkg.sv =====
// ----------------------------------------------------------------------------
// Capped cylinder intersect package
// Shared types, constants and the sequencer program of the capped cylinder
// intersection block.
// ----------------------------------------------------------------------------
package cci_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int FX_W          = 64;
   localparam int SLOT_DEPTH    = 64;
   localparam int SLOT_AW       = 6;
   localparam int OPD_W         = 7;
   localparam int PC_W          = 7;
   localparam int SQ_DIGITS     = 48;
   localparam int SQ_NW         = 2 * SQ_DIGITS;
   localparam int CSR_IDX_W     = 4;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic signed [FX_W-1:0] FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [FX_W-1:0] FX_MIN = -64'sh7FFF_FFFF_FFFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_X = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Y = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Z = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_X = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_Y = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_Z = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 4'd7;

   localparam logic [1:0] SURF_SIDE = 2'd0;
   localparam logic [1:0] SURF_BASE = 2'd1;
   localparam logic [1:0] SURF_LID  = 2'd2;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_SQRT
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_SQRT,
      ST_DECIDE
   } st_type;

   typedef struct packed {
      op_type           op;
      logic [OPD_W-1:0] dst;
      logic [OPD_W-1:0] sa;
      logic [OPD_W-1:0] sb;
   } instr_type;

   typedef struct packed {
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
      logic signed [17:0] ux;
      logic signed [17:0] uy;
      logic signed [17:0] uz;
      logic [30:0]        r;
      logic [30:0]        h;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
      logic signed [32:0] vx;
      logic signed [32:0] vy;
      logic signed [32:0] vz;
   } item_type;

   // Scratch slots held in the operand memories.
   localparam logic [OPD_W-1:0] R_T0    = 7'd0;
   localparam logic [OPD_W-1:0] R_T1    = 7'd1;
   localparam logic [OPD_W-1:0] R_T2    = 7'd2;
   localparam logic [OPD_W-1:0] R_T3    = 7'd3;
   localparam logic [OPD_W-1:0] R_TCX   = 7'd4;
   localparam logic [OPD_W-1:0] R_TCY   = 7'd5;
   localparam logic [OPD_W-1:0] R_TCZ   = 7'd6;
   localparam logic [OPD_W-1:0] R_DU    = 7'd7;
   localparam logic [OPD_W-1:0] R_VU    = 7'd8;
   localparam logic [OPD_W-1:0] R_DPX   = 7'd9;
   localparam logic [OPD_W-1:0] R_DPY   = 7'd10;
   localparam logic [OPD_W-1:0] R_DPZ   = 7'd11;
   localparam logic [OPD_W-1:0] R_VPX   = 7'd12;
   localparam logic [OPD_W-1:0] R_VPY   = 7'd13;
   localparam logic [OPD_W-1:0] R_VPZ   = 7'd14;
   localparam logic [OPD_W-1:0] R_R2    = 7'd15;
   localparam logic [OPD_W-1:0] R_A     = 7'd16;
   localparam logic [OPD_W-1:0] R_B     = 7'd17;
   localparam logic [OPD_W-1:0] R_C     = 7'd18;
   localparam logic [OPD_W-1:0] R_DELTA = 7'd19;
   localparam logic [OPD_W-1:0] R_S     = 7'd20;
   localparam logic [OPD_W-1:0] R_TWOA  = 7'd21;
   localparam logic [OPD_W-1:0] R_NB    = 7'd22;
   localparam logic [OPD_W-1:0] R_T1R   = 7'd23;
   localparam logic [OPD_W-1:0] R_T2R   = 7'd24;
   localparam logic [OPD_W-1:0] R_AX1   = 7'd25;
   localparam logic [OPD_W-1:0] R_AX2   = 7'd26;
   localparam logic [OPD_W-1:0] R_TB    = 7'd27;
   localparam logic [OPD_W-1:0] R_TL    = 7'd28;
   localparam logic [OPD_W-1:0] R_QX    = 7'd29;
   localparam logic [OPD_W-1:0] R_QY    = 7'd30;
   localparam logic [OPD_W-1:0] R_QZ    = 7'd31;
   localparam logic [OPD_W-1:0] R_QQB   = 7'd32;
   localparam logic [OPD_W-1:0] R_QQL   = 7'd33;

   // Operands taken from the ray and the registers.
   localparam logic [OPD_W-1:0] X_PX   = 7'd64;
   localparam logic [OPD_W-1:0] X_PY   = 7'd65;
   localparam logic [OPD_W-1:0] X_PZ   = 7'd66;
   localparam logic [OPD_W-1:0] X_DX   = 7'd67;
   localparam logic [OPD_W-1:0] X_DY   = 7'd68;
   localparam logic [OPD_W-1:0] X_DZ   = 7'd69;
   localparam logic [OPD_W-1:0] X_VX   = 7'd70;
   localparam logic [OPD_W-1:0] X_VY   = 7'd71;
   localparam logic [OPD_W-1:0] X_VZ   = 7'd72;
   localparam logic [OPD_W-1:0] X_BX   = 7'd73;
   localparam logic [OPD_W-1:0] X_BY   = 7'd74;
   localparam logic [OPD_W-1:0] X_BZ   = 7'd75;
   localparam logic [OPD_W-1:0] X_UX   = 7'd76;
   localparam logic [OPD_W-1:0] X_UY   = 7'd77;
   localparam logic [OPD_W-1:0] X_UZ   = 7'd78;
   localparam logic [OPD_W-1:0] X_R    = 7'd79;
   localparam logic [OPD_W-1:0] X_H    = 7'd80;
   localparam logic [OPD_W-1:0] X_ZERO = 7'd81;

   localparam int PROG_LEN = 108;

   function automatic instr_type ins(input op_type op, input logic [OPD_W-1:0] d,
                                     input logic [OPD_W-1:0] a,
                                     input logic [OPD_W-1:0] b);
      instr_type i;
      i.op  = op;
      i.dst = d;
      i.sa  = a;
      i.sb  = b;
      return i;
   endfunction

   function automatic logic [FX_W-1:0] mag64(input logic signed [FX_W-1:0] x);
      return x[FX_W-1] ? FX_W'(-x) : FX_W'(x);
   endfunction

   function automatic instr_type prog(input logic [PC_W-1:0] pc);
      instr_type p;
      case (pc)
         7'd0:   p = ins(OP_MUL, R_T0, X_UX, X_H);
         7'd1:   p = ins(OP_ADD, R_TCX, X_BX, R_T0);
         7'd2:   p = ins(OP_MUL, R_T0, X_UY, X_H);
         7'd3:   p = ins(OP_ADD, R_TCY, X_BY, R_T0);
         7'd4:   p = ins(OP_MUL, R_T0, X_UZ, X_H);
         7'd5:   p = ins(OP_ADD, R_TCZ, X_BZ, R_T0);
         7'd6:   p = ins(OP_MUL, R_T0, X_DX, X_UX);
         7'd7:   p = ins(OP_MUL, R_T1, X_DY, X_UY);
         7'd8:   p = ins(OP_ADD, R_T0, R_T0, R_T1);
         7'd9:   p = ins(OP_MUL, R_T1, X_DZ, X_UZ);
         7'd10:  p = ins(OP_ADD, R_DU, R_T0, R_T1);
         7'd11:  p = ins(OP_MUL, R_T0, X_VX, X_UX);
         7'd12:  p = ins(OP_MUL, R_T1, X_VY, X_UY);
         7'd13:  p = ins(OP_ADD, R_T0, R_T0, R_T1);
         7'd14:  p = ins(OP_MUL, R_T1, X_VZ, X_UZ);
         7'd15:  p = ins(OP_ADD, R_VU, R_T0, R_T1);
         7'd16:  p = ins(OP_MUL, R_T0, X_UX, R_DU);
         7'd17:  p = ins(OP_SUB, R_DPX, X_DX, R_T0);
         7'd18:  p = ins(OP_MUL, R_T0, X_UY, R_DU);
         7'd19:  p = ins(OP_SUB, R_DPY, X_DY, R_T0);
         7'd20:  p = ins(OP_MUL, R_T0, X_UZ, R_DU);
         7'd21:  p = ins(OP_SUB, R_DPZ, X_DZ, R_T0);
         7'd22:  p = ins(OP_MUL, R_T0, X_UX, R_VU);
         7'd23:  p = ins(OP_SUB, R_VPX, X_VX, R_T0);
         7'd24:  p = ins(OP_MUL, R_T0, X_UY, R_VU);
         7'd25:  p = ins(OP_SUB, R_VPY, X_VY, R_T0);
         7'd26:  p = ins(OP_MUL, R_T0, X_UZ, R_VU);
         7'd27:  p = ins(OP_SUB, R_VPZ, X_VZ, R_T0);
         7'd28:  p = ins(OP_MUL, R_R2, X_R, X_R);
         7'd29:  p = ins(OP_MUL, R_T0, R_DPX, R_DPX);
         7'd30:  p = ins(OP_MUL, R_T1, R_DPY, R_DPY);
         7'd31:  p = ins(OP_ADD, R_T0, R_T0, R_T1);
         7'd32:  p = ins(OP_MUL, R_T1, R_DPZ, R_DPZ);
         7'd33:  p = ins(OP_ADD, R_A, R_T0, R_T1);
         7'd34:  p = ins(OP_MUL, R_T0, R_VPX, R_DPX);
         7'd35:  p = ins(OP_MUL, R_T1, R_VPY, R_DPY);
         7'd36:  p = ins(OP_ADD, R_T0, R_T0, R_T1);
         7'd37:  p = ins(OP_MUL, R_T1, R_VPZ, R_DPZ);
         7'd38:  p = ins(OP_ADD, R_T2, R_T0, R_T1);
         7'd39:  p = ins(OP_ADD, R_B, R_T2, R_T2);
         7'd40:  p = ins(OP_MUL, R_T0, R_VPX, R_VPX);
         7'd41:  p = ins(OP_MUL, R_T1, R_VPY, R_VPY);
         7'd42:  p = ins(OP_ADD, R_T0, R_T0, R_T1);
         7'd43:  p = ins(OP_MUL, R_T1, R_VPZ, R_VPZ);
         7'd44:  p = ins(OP_ADD, R_T2, R_T0, R_T1);
         7'd45:  p = ins(OP_SUB, R_C, R_T2, R_R2);
         7'd46:  p = ins(OP_MUL, R_T0, R_A, R_C);
         7'd47:  p = ins(OP_ADD, R_T0, R_T0, R_T0);
         7'd48:  p = ins(OP_ADD, R_T0, R_T0, R_T0);
         7'd49:  p = ins(OP_MUL, R_T1, R_B, R_B);
         7'd50:  p = ins(OP_SUB, R_DELTA, R_T1, R_T0);
         7'd51:  p = ins(OP_SQRT, R_S, R_DELTA, R_DELTA);
         7'd52:  p = ins(OP_ADD, R_TWOA, R_A, R_A);
         7'd53:  p = ins(OP_SUB, R_NB, X_ZERO, R_B);
         7'd54:  p = ins(OP_ADD, R_T0, R_NB, R_S);
         7'd55:  p = ins(OP_DIV, R_T1R, R_T0, R_TWOA);
         7'd56:  p = ins(OP_SUB, R_T0, R_NB, R_S);
         7'd57:  p = ins(OP_DIV, R_T2R, R_T0, R_TWOA);
         7'd58:  p = ins(OP_MUL, R_T0, R_DU, R_T1R);
         7'd59:  p = ins(OP_ADD, R_AX1, R_VU, R_T0);
         7'd60:  p = ins(OP_MUL, R_T0, R_DU, R_T2R);
         7'd61:  p = ins(OP_ADD, R_AX2, R_VU, R_T0);
         7'd62:  p = ins(OP_SUB, R_T0, X_BX, X_PX);
         7'd63:  p = ins(OP_MUL, R_T3, R_T0, X_UX);
         7'd64:  p = ins(OP_SUB, R_T0, X_BY, X_PY);
         7'd65:  p = ins(OP_MUL, R_T1, R_T0, X_UY);
         7'd66:  p = ins(OP_ADD, R_T3, R_T3, R_T1);
         7'd67:  p = ins(OP_SUB, R_T0, X_BZ, X_PZ);
         7'd68:  p = ins(OP_MUL, R_T1, R_T0, X_UZ);
         7'd69:  p = ins(OP_ADD, R_T3, R_T3, R_T1);
         7'd70:  p = ins(OP_DIV, R_TB, R_T3, R_DU);
         7'd71:  p = ins(OP_MUL, R_T0, X_DX, R_TB);
         7'd72:  p = ins(OP_ADD, R_T0, X_PX, R_T0);
         7'd73:  p = ins(OP_SUB, R_QX, R_T0, X_BX);
         7'd74:  p = ins(OP_MUL, R_T0, X_DY, R_TB);
         7'd75:  p = ins(OP_ADD, R_T0, X_PY, R_T0);
         7'd76:  p = ins(OP_SUB, R_QY, R_T0, X_BY);
         7'd77:  p = ins(OP_MUL, R_T0, X_DZ, R_TB);
         7'd78:  p = ins(OP_ADD, R_T0, X_PZ, R_T0);
         7'd79:  p = ins(OP_SUB, R_QZ, R_T0, X_BZ);
         7'd80:  p = ins(OP_MUL, R_T0, R_QX, R_QX);
         7'd81:  p = ins(OP_MUL, R_T1, R_QY, R_QY);
         7'd82:  p = ins(OP_ADD, R_T0, R_T0, R_T1);
         7'd83:  p = ins(OP_MUL, R_T1, R_QZ, R_QZ);
         7'd84:  p = ins(OP_ADD, R_QQB, R_T0, R_T1);
         7'd85:  p = ins(OP_SUB, R_T0, R_TCX, X_PX);
         7'd86:  p = ins(OP_MUL, R_T3, R_T0, X_UX);
         7'd87:  p = ins(OP_SUB, R_T0, R_TCY, X_PY);
         7'd88:  p = ins(OP_MUL, R_T1, R_T0, X_UY);
         7'd89:  p = ins(OP_ADD, R_T3, R_T3, R_T1);
         7'd90:  p = ins(OP_SUB, R_T0, R_TCZ, X_PZ);
         7'd91:  p = ins(OP_MUL, R_T1, R_T0, X_UZ);
         7'd92:  p = ins(OP_ADD, R_T3, R_T3, R_T1);
         7'd93:  p = ins(OP_DIV, R_TL, R_T3, R_DU);
         7'd94:  p = ins(OP_MUL, R_T0, X_DX, R_TL);
         7'd95:  p = ins(OP_ADD, R_T0, X_PX, R_T0);
         7'd96:  p = ins(OP_SUB, R_QX, R_T0, R_TCX);
         7'd97:  p = ins(OP_MUL, R_T0, X_DY, R_TL);
         7'd98:  p = ins(OP_ADD, R_T0, X_PY, R_T0);
         7'd99:  p = ins(OP_SUB, R_QY, R_T0, R_TCY);
         7'd100: p = ins(OP_MUL, R_T0, X_DZ, R_TL);
         7'd101: p = ins(OP_ADD, R_T0, X_PZ, R_T0);
         7'd102: p = ins(OP_SUB, R_QZ, R_T0, R_TCZ);
         7'd103: p = ins(OP_MUL, R_T0, R_QX, R_QX);
         7'd104: p = ins(OP_MUL, R_T1, R_QY, R_QY);
         7'd105: p = ins(OP_ADD, R_T0, R_T0, R_T1);
         7'd106: p = ins(OP_MUL, R_T1, R_QZ, R_QZ);
         7'd107: p = ins(OP_ADD, R_QQL, R_T0, R_T1);
         default: p = ins(OP_ADD, R_T0, X_ZERO, X_ZERO);
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/core/cci_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module cci_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/core/cci_front.sv =====
// ----------------------------------------------------------------------------
// Capped cylinder intersect front end
// Accepts rays, forms the origin offset from the base centre and holds the
// items in a short queue for the back end.
// ----------------------------------------------------------------------------
module cci_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [191:0]      req_tdata,
   input  cci_pkg::cfg_type  cfg,
   output logic              item_valid,
   input  logic              item_pop,
   output cci_pkg::item_type item
);
   import cci_pkg::*;

   localparam int QAW = $clog2(QUEUE_DEPTH);

   item_type       entry_ff [QUEUE_DEPTH];
   item_type       entry_in;
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;
   logic           push;

   assign req_tready = (count_ff != (QAW+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != '0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in.px = req_tdata[31:0];
      entry_in.py = req_tdata[63:32];
      entry_in.pz = req_tdata[95:64];
      entry_in.dx = req_tdata[127:96];
      entry_in.dy = req_tdata[159:128];
      entry_in.dz = req_tdata[191:160];
      entry_in.vx = 33'(entry_in.px) - 33'(cfg.bx);
      entry_in.vy = 33'(entry_in.py) - 33'(cfg.by);
      entry_in.vz = 33'(entry_in.pz) - 33'(cfg.bz);
      wr_ptr_in   = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in   = item_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in    = count_ff + (QAW+1)'(push) - (QAW+1)'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// ===== rtl/core/cci_back.sv =====
// ----------------------------------------------------------------------------
// Capped cylinder intersect back end
// Sequencer that runs the intersection program over a shared saturating
// adder, a multi-cycle multiplier, a restoring divider and a square root.
// ----------------------------------------------------------------------------
module cci_back #(
   parameter int FRAC_BITS = cci_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_pop,
   input  cci_pkg::item_type item,
   input  cci_pkg::cfg_type  cfg,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   output logic [2:0]        rsp_tuser
);
   import cci_pkg::*;

   localparam int DIV_STEPS = FX_W + FRAC_BITS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   st_type                  state_ff, state_in;
   logic [PC_W-1:0]         pc_ff, pc_in;
   logic [CNT_W-1:0]        cnt_ff;
   item_type                item_ff;
   instr_type               cur;
   logic signed [FX_W-1:0]  ext_a_ff, ext_b_ff, ram_a, ram_b, opa, opb;
   logic                    last, unit_done;
   logic                    fetch, start, step, wb_en, out_load;
   logic signed [FX_W-1:0]  wb_data, add_res, mul_res, div_res;
   logic signed [FX_W:0]    sum;
   logic                    neg_ff, ovf_ff;
   logic [FX_W-1:0]         ma_ff, mb_ff;
   logic [2*FX_W-1:0]       acc_ff, acc_sh, partial;
   logic [31:0]             pa, pb;
   logic [63:0]             pprod;
   logic [1:0]              pk;
   logic [SQ_NW-1:0]        nsh_ff;
   logic [FX_W-1:0]         rem_ff;
   logic [FX_W:0]           drem_t;
   logic                    dge;
   logic [FX_W-2:0]         q_ff;
   logic [CNT_W-1:0]        didx;
   logic [SQ_DIGITS+3:0]    srem_t, strial;
   logic                    sge;
   logic [SQ_DIGITS-1:0]    root_ff;
   logic signed [FX_W-1:0]  cap_a, cap_delta, cap_t1, cap_t2, cap_ax1, cap_ax2;
   logic signed [FX_W-1:0]  cap_du, cap_tb, cap_tl, cap_qqb, cap_qql, cap_r2;
   logic signed [FX_W-1:0]  height, best, side_best, distance;
   logic                    ok1, ok2, hb, hl, have;
   logic [1:0]              surf;

   function automatic logic signed [FX_W-1:0] ext_sel(input logic [OPD_W-1:0] s,
                                                     input item_type it,
                                                     input cfg_type c);
      logic signed [FX_W-1:0] v;
      case (s)
         X_PX:    v = FX_W'(it.px);
         X_PY:    v = FX_W'(it.py);
         X_PZ:    v = FX_W'(it.pz);
         X_DX:    v = FX_W'(it.dx);
         X_DY:    v = FX_W'(it.dy);
         X_DZ:    v = FX_W'(it.dz);
         X_VX:    v = FX_W'(it.vx);
         X_VY:    v = FX_W'(it.vy);
         X_VZ:    v = FX_W'(it.vz);
         X_BX:    v = FX_W'(c.bx);
         X_BY:    v = FX_W'(c.by);
         X_BZ:    v = FX_W'(c.bz);
         X_UX:    v = FX_W'(c.ux);
         X_UY:    v = FX_W'(c.uy);
         X_UZ:    v = FX_W'(c.uz);
         X_R:     v = $signed({33'd0, c.r});
         X_H:     v = $signed({33'd0, c.h});
         default: v = '0;
      endcase
      return v;
   endfunction

   assign cur  = prog(pc_ff);
   assign last = (pc_ff == PC_W'(PROG_LEN - 1));
   assign opa  = cur.sa[OPD_W-1] ? ext_a_ff : ram_a;
   assign opb  = cur.sb[OPD_W-1] ? ext_b_ff : ram_b;
   assign unit_done = (cnt_ff == '0);

   cci_ram #(.WIDTH(FX_W), .DEPTH(SLOT_DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (cur.dst[SLOT_AW-1:0]),
      .wr_data (wb_data),
      .rd_addr (cur.sa[SLOT_AW-1:0]),
      .rd_data (ram_a)
   );

   cci_ram #(.WIDTH(FX_W), .DEPTH(SLOT_DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wb_en),
      .wr_addr (cur.dst[SLOT_AW-1:0]),
      .wr_data (wb_data),
      .rd_addr (cur.sb[SLOT_AW-1:0]),
      .rd_data (ram_b)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (item_valid) state_in = ST_FETCH;
         ST_FETCH:  state_in = ST_EXEC;
         ST_EXEC: begin
            case (cur.op)
               OP_MUL:  state_in = ST_MUL;
               OP_DIV:  state_in = ST_DIV;
               OP_SQRT: state_in = ST_SQRT;
               default: state_in = last ? ST_DECIDE : ST_FETCH;
            endcase
         end
         ST_MUL, ST_DIV, ST_SQRT: begin
            if (unit_done) state_in = last ? ST_DECIDE : ST_FETCH;
         end
         ST_DECIDE: if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control strobes.
   always_comb begin
      item_pop = 1'b0;
      fetch    = 1'b0;
      start    = 1'b0;
      step     = 1'b0;
      wb_en    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE:  item_pop = item_valid;
         ST_FETCH: fetch = 1'b1;
         ST_EXEC: begin
            start = 1'b1;
            wb_en = (cur.op == OP_ADD) || (cur.op == OP_SUB);
         end
         ST_MUL, ST_DIV, ST_SQRT: begin
            step  = !unit_done;
            wb_en = unit_done;
         end
         ST_DECIDE: out_load = !rsp_tvalid || rsp_tready;
         default: ;
      endcase
   end

   // Saturating add and subtract.
   always_comb begin
      if (cur.op == OP_SUB) begin
         sum = {opa[FX_W-1], opa} - {opb[FX_W-1], opb};
      end else begin
         sum = {opa[FX_W-1], opa} + {opb[FX_W-1], opb};
      end
      if (sum > (FX_W+1)'(FX_MAX)) begin
         add_res = FX_MAX;
      end else if (sum < (FX_W+1)'(FX_MIN)) begin
         add_res = FX_MIN;
      end else begin
         add_res = sum[FX_W-1:0];
      end
   end

   // Multiplier: one 32 by 32 partial product a cycle.
   always_comb begin
      pk      = cnt_ff[1:0] - 2'd1;
      pa      = pk[1] ? ma_ff[63:32] : ma_ff[31:0];
      pb      = pk[0] ? mb_ff[63:32] : mb_ff[31:0];
      pprod   = pa * pb;
      partial = {64'd0, pprod} << (32 * (32'(pk[1]) + 32'(pk[0])));
      acc_sh  = acc_ff >> FRAC_BITS;
      if (acc_sh[2*FX_W-1:FX_W] != '0 || acc_sh[FX_W-1]) begin
         mul_res = neg_ff ? FX_MIN : FX_MAX;
      end else begin
         mul_res = neg_ff ? -$signed(acc_sh[FX_W-1:0]) : $signed(acc_sh[FX_W-1:0]);
      end
   end

   // Divider: one quotient bit a cycle.
   always_comb begin
      didx   = cnt_ff - 1'b1;
      drem_t = {rem_ff, nsh_ff[SQ_NW-1]};
      dge    = (drem_t >= {1'b0, mb_ff});
      if (ovf_ff) begin
         div_res = neg_ff ? FX_MIN : FX_MAX;
      end else begin
         div_res = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      end
   end

   // Square root: one result bit a cycle.
   always_comb begin
      srem_t = {rem_ff[SQ_DIGITS+1:0], nsh_ff[SQ_NW-1:SQ_NW-2]};
      strial = {2'b00, root_ff, 2'b01};
      sge    = (srem_t >= strial);
   end

   always_comb begin
      case (state_ff)
         ST_MUL:  wb_data = mul_res;
         ST_DIV:  wb_data = div_res;
         ST_SQRT: wb_data = $signed(FX_W'(root_ff));
         default: wb_data = add_res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (item_pop) begin
            pc_ff <= '0;
         end else if (wb_en) begin
            pc_ff <= pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         item_ff <= item;
      end
      if (fetch) begin
         ext_a_ff <= ext_sel(cur.sa, item_ff, cfg);
         ext_b_ff <= ext_sel(cur.sb, item_ff, cfg);
      end
      if (start) begin
         neg_ff  <= opa[FX_W-1] ^ opb[FX_W-1];
         ma_ff   <= mag64(opa);
         mb_ff   <= mag64(opb);
         acc_ff  <= '0;
         rem_ff  <= '0;
         q_ff    <= '0;
         root_ff <= '0;
         ovf_ff  <= 1'b0;
         case (cur.op)
            OP_MUL: cnt_ff <= CNT_W'(4);
            OP_DIV: begin
               cnt_ff <= CNT_W'(DIV_STEPS);
               nsh_ff <= {mag64(opa), (SQ_NW-FX_W)'(0)};
            end
            OP_SQRT: begin
               cnt_ff <= CNT_W'(SQ_DIGITS);
               nsh_ff <= (opa > 0) ? (SQ_NW'(opa) << FRAC_BITS) : '0;
            end
            default: cnt_ff <= '0;
         endcase
      end else if (step) begin
         cnt_ff <= cnt_ff - 1'b1;
         case (state_ff)
            ST_MUL: acc_ff <= acc_ff + partial;
            ST_DIV: begin
               nsh_ff <= nsh_ff << 1;
               rem_ff <= dge ? FX_W'(drem_t - {1'b0, mb_ff}) : drem_t[FX_W-1:0];
               q_ff   <= {q_ff[FX_W-3:0], dge && (didx < CNT_W'(FX_W-1))};
               if (dge && didx >= CNT_W'(FX_W-1)) ovf_ff <= 1'b1;
            end
            ST_SQRT: begin
               nsh_ff  <= nsh_ff << 2;
               rem_ff  <= FX_W'(sge ? srem_t - strial : srem_t);
               root_ff <= {root_ff[SQ_DIGITS-2:0], sge};
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wb_en) begin
         case (cur.dst)
            R_A:     cap_a     <= wb_data;
            R_DELTA: cap_delta <= wb_data;
            R_T1R:   cap_t1    <= wb_data;
            R_T2R:   cap_t2    <= wb_data;
            R_AX1:   cap_ax1   <= wb_data;
            R_AX2:   cap_ax2   <= wb_data;
            R_DU:    cap_du    <= wb_data;
            R_TB:    cap_tb    <= wb_data;
            R_TL:    cap_tl    <= wb_data;
            R_QQB:   cap_qqb   <= wb_data;
            R_QQL:   cap_qql   <= wb_data;
            R_R2:    cap_r2    <= wb_data;
            default: ;
         endcase
      end
   end

   // Choice between side wall and disk hits.
   always_comb begin
      height = $signed({33'd0, cfg.h});
      ok1 = (cap_a > 0) && (cap_delta > 0) && (cap_t1 > 0) && (cap_ax1 > 0)
            && (cap_ax1 <= height);
      ok2 = (cap_a > 0) && (cap_delta > 0) && (cap_t2 > 0) && (cap_ax2 > 0)
            && (cap_ax2 <= height);
      hb  = (cap_du != 0) && (cap_tb > 0) && (cap_qqb <= cap_r2);
      hl  = (cap_du != 0) && (cap_tl > 0) && (cap_qql <= cap_r2);
      side_best = ok1 ? cap_t1 : cap_t2;
      surf = SURF_SIDE;
      if (ok1 && ok2) begin
         best = (cap_t1 < cap_t2) ? cap_t1 : cap_t2;
         have = 1'b1;
      end else begin
         best = side_best;
         have = ok1 || ok2;
         if (hb && (!have || cap_tb < best)) begin
            best = cap_tb;
            surf = SURF_BASE;
            have = 1'b1;
         end
         if (hl && (!have || cap_tl < best)) begin
            best = cap_tl;
            surf = SURF_LID;
            have = 1'b1;
         end
      end
      if (!have) begin
         distance = -(FX_W'(1) << FRAC_BITS);
         surf = SURF_SIDE;
      end else if (best > 64'sh7FFF_FFFF) begin
         distance = 64'sh7FFF_FFFF;
      end else if (best < -64'sh8000_0000) begin
         distance = -64'sh8000_0000;
      end else begin
         distance = best;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (out_load) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata <= distance[31:0];
         rsp_tuser <= {surf, have};
      end
   end

endmodule

// ===== rtl/core/ray_capped_cylinder_intersect.sv =====
// ----------------------------------------------------------------------------
// Ray against capped cylinder intersection
// Intersects each ray with a configured capped cylinder in fixed point and
// reports hit, ray parameter and surface.
// ----------------------------------------------------------------------------
// Rays arrive on the req_ stream, one transfer per ray, and are held in a
// four-entry queue, so up to four rays are taken while the engine is busy.
// The back end works on one ray at a time and runs a fixed program of 108
// operations: additions, multiplications of four 32 by 32 partial products,
// the square root and four divisions, each one quotient bit a cycle.
// Each ray gives exactly one rsp_ transfer; a finished result waits in the
// output register while the next ray is already under way, and the engine
// stops only when a second result is ready before the first is taken.
// The csr_ channel writes one register per transfer and is always ready;
// the user must write it only while no ray is in flight; the block itself
// does not enforce this. Reset empties the queue, returns the sequencer to
// idle and loads the register reset values.
// ----------------------------------------------------------------------------
module ray_capped_cylinder_intersect #(
   parameter int FRAC_BITS = cci_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // org_x, org_y, org_z, dir_x, dir_y, dir_z
   input  logic [191:0]                   req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // distance
   output logic [31:0]                    rsp_tdata,
   // hit, surface
   output logic [2:0]                     rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cci_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_data
);
   import cci_pkg::*;

   cfg_type  cfg_ff;
   logic     item_valid, item_pop;
   item_type item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bx <= '0;
         cfg_ff.by <= '0;
         cfg_ff.bz <= '0;
         cfg_ff.ux <= '0;
         cfg_ff.uy <= '0;
         cfg_ff.uz <= 18'sd65536;
         cfg_ff.r  <= 31'd65536;
         cfg_ff.h  <= 31'd65536;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_X: cfg_ff.bx <= csr_data;
            CSR_BASE_Y: cfg_ff.by <= csr_data;
            CSR_BASE_Z: cfg_ff.bz <= csr_data;
            CSR_AXIS_X: cfg_ff.ux <= csr_data[17:0];
            CSR_AXIS_Y: cfg_ff.uy <= csr_data[17:0];
            CSR_AXIS_Z: cfg_ff.uz <= csr_data[17:0];
            CSR_RADIUS: cfg_ff.r  <= csr_data[30:0];
            CSR_HEIGHT: cfg_ff.h  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   cci_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   cci_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .cfg        (cfg_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_miss_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp_tdata == (32'hFFFF_FFFF << FRAC_BITS) && rsp_tuser[2:1] == SURF_SIDE)
      else $error("miss result carries a distance or surface");

   a_surface_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[2:1] != 2'd3)
      else $error("surface code out of range");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented straight after reset");

endmodule
